### rtl/core/bpa_pkg.sv
// Buddy page allocator: shared constants, field widths and status codes.
// No dependencies.
`default_nettype none

package bpa_pkg;

  localparam int DEF_PAGES      = 64;
  localparam int DEF_TOP_ORDER  = 6;
  localparam int DEF_PAGE_SHIFT = 21;

  localparam int SIZE_W = 32;
  localparam int PG_W   = 6;
  localparam int ORD_W  = 3;
  localparam int OFF_W  = 27;
  localparam int ST_W   = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_MEM    = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_FREE  = 2'd3;

endpackage

`default_nettype wire

### rtl/core/bpa_ram.sv
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
`default_nettype none

module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/bpa_store.sv
// Per-page state store: RAM plus per-entry valid bits giving reset contents,
// with a word written in the cycle of its read forwarded. Depends on bpa_ram.
`default_nettype none

module bpa_store #(
  parameter int          W = 8,
  parameter int          D = 16,
  parameter logic [W-1:0] RST_FIRST = '0,
  parameter logic [W-1:0] RST_OTHER = '0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  localparam int AW = $clog2(D);

  logic [W-1:0]  ram_q;
  logic [AW-1:0] raddr_q;
  logic [D-1:0]  vld;
  logic          fwd;
  logic [W-1:0]  fwd_data;

  bpa_ram #(.W(W), .D(D)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    fwd <= we && (waddr == raddr);
    fwd_data <= wdata;
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_comb begin
    if (fwd) begin
      rdata = fwd_data;
    end else if (vld[raddr_q]) begin
      rdata = ram_q;
    end else if (raddr_q == '0) begin
      rdata = RST_FIRST;
    end else begin
      rdata = RST_OTHER;
    end
  end

endmodule

`default_nettype wire

### rtl/core/buddy_page_allocator_core.sv
// Buddy page allocator top level: request sequencer and free-list heads.
// Depends on bpa_pkg and bpa_store.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: req_type,
//   request_size (allocate) or block_page (free). Output channel
//   (out_valid/out_ready) returns one result word per request: status,
//   page_index, block_order, byte_offset.
//   Requests are handled one at a time. in_ready is high only while the
//   sequencer is idle. Per-page state (free flag, order, list links) sits in
//   one RAM with a registered read; each list-link update is a
//   read-modify-write of that RAM.
//   The output register holds a finished result while the receiver stalls;
//   the next request is taken meanwhile but its result waits for the slot.
//   Reset (synchronous) returns to one free block of the top order at page 0.
//   No clearing pass: per-entry valid bits supply the reset contents.
`default_nettype none

module buddy_page_allocator_core import bpa_pkg::*; #(
  parameter int PAGES      = DEF_PAGES,
  parameter int TOP_ORDER  = DEF_TOP_ORDER,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [SIZE_W-1:0] request_size,
  input  wire logic [PG_W-1:0]   block_page,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [ST_W-1:0]   status,
  output logic      [PG_W-1:0]   page_index,
  output logic      [ORD_W-1:0]  block_order,
  output logic      [OFF_W-1:0]  byte_offset
);

  localparam int STORE = (PAGES > (1 << TOP_ORDER)) ? PAGES : (1 << TOP_ORDER);
  localparam int AW    = $clog2(STORE);
  localparam int LW    = $clog2(STORE + 1);
  localparam int OW    = $clog2(TOP_ORDER + 1);
  localparam int EW    = 1 + OW + 2 * LW;
  localparam int SUM_W = SIZE_W + 1;
  localparam logic [LW-1:0] NIL = LW'(STORE);
  localparam logic [OW-1:0] TOP = OW'(TOP_ORDER);

  typedef struct packed {
    logic          free;
    logic [OW-1:0] order;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } entry_t;

  localparam entry_t ENT_FIRST = '{free: 1'b1, order: TOP, nxt: NIL, prv: NIL};
  localparam entry_t ENT_OTHER = '{free: 1'b0, order: '0, nxt: NIL, prv: NIL};

  typedef enum logic [3:0] {
    S_IDLE, S_SIZE, S_SRCH, S_SPLIT, S_FCHK, S_FE, S_FLOOP, S_FBD,
    S_UE, S_UQ, S_UN, S_PW, S_PH, S_OUT
  } state_t;

  state_t state, ret;

  logic [LW-1:0]     head [TOP_ORDER+1];
  logic [SIZE_W-1:0] size_q;
  logic [PG_W-1:0]   bp_in;
  logic [OW-1:0]     target, cur, o;
  logic [AW-1:0]     bp, p, bd;
  logic [AW-1:0]     ul_p, ps_p;
  logic [OW-1:0]     ul_o, ul_order, ps_o;
  logic [LW-1:0]     ul_q, ul_n, ph;
  logic [ST_W-1:0]   res_st;
  logic [PG_W-1:0]   res_pg;
  logic [OW-1:0]     res_ord;
  logic              alloc_ok;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rd;
  logic [EW-1:0] rdata;

  logic [SUM_W-1:0] pages;
  logic             too_large;
  logic [OW-1:0]    tgt_c;
  logic             found;
  logic [OW-1:0]    found_o;
  logic [AW-1:0]    bd_c;
  logic             bd_oob;

  bpa_store #(
    .W(EW), .D(STORE), .RST_FIRST(ENT_FIRST), .RST_OTHER(ENT_OTHER)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd = entry_t'(rdata);
  assign in_ready = (state == S_IDLE);

  // size to order
  always_comb begin
    pages = (SUM_W'(size_q) + SUM_W'((64'd1 << PAGE_SHIFT) - 64'd1)) >> PAGE_SHIFT;
    too_large = pages > (SUM_W'(1) << TOP_ORDER);
    tgt_c = TOP;
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (pages <= (SUM_W'(1) << i)) begin
        tgt_c = OW'(i);
      end
    end
  end

  // first non-empty list at or above target
  always_comb begin
    found = 1'b0;
    found_o = '0;
    for (int i = 0; i <= TOP_ORDER; i++) begin
      if (!found && OW'(i) >= target && head[i] != NIL) begin
        found = 1'b1;
        found_o = OW'(i);
      end
    end
  end

  assign bd_c   = p ^ (AW'(1) << o);
  assign bd_oob = 32'(bd_c) >= PAGES;

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = ENT_OTHER;
    raddr = '0;
    case (state)
      S_SRCH:  raddr = AW'(head[found_o]);
      S_FCHK:  raddr = AW'(bp_in);
      S_FLOOP: raddr = bd_c;
      S_FBD:   raddr = bd;
      S_UE: begin
        we = 1'b1;
        waddr = ul_p;
        wdata = '{free: 1'b0, order: ul_order, nxt: NIL, prv: NIL};
        raddr = (rd.prv < NIL) ? AW'(rd.prv) : AW'(rd.nxt);
      end
      // a neighbour that is the unlinked entry itself keeps its cleared word
      S_UQ: begin
        we = (AW'(ul_q) != ul_p);
        waddr = AW'(ul_q);
        wdata = rd;
        wdata.nxt = ul_n;
        raddr = AW'(ul_n);
      end
      S_UN: begin
        we = (AW'(ul_n) != ul_p);
        waddr = AW'(ul_n);
        wdata = rd;
        wdata.prv = ul_q;
      end
      S_PW: begin
        we = 1'b1;
        waddr = ps_p;
        wdata = '{free: 1'b1, order: ps_o, nxt: head[ps_o], prv: NIL};
        raddr = AW'(head[ps_o]);
      end
      S_PH: begin
        we = 1'b1;
        waddr = AW'(ph);
        wdata = rd;
        wdata.prv = LW'(ps_p);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
        head[i] <= (i == TOP_ORDER) ? '0 : NIL;
      end
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            size_q <= request_size;
            bp_in <= block_page;
            res_st <= ST_OK;
            res_pg <= '0;
            res_ord <= '0;
            alloc_ok <= 1'b0;
            state <= (req_type == REQ_FREE) ? S_FCHK : S_SIZE;
          end
        end
        S_SIZE: begin
          if (too_large) begin
            res_st <= ST_TOO_LARGE;
            state <= S_OUT;
          end else begin
            target <= tgt_c;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (!found) begin
            res_st <= ST_NO_MEM;
            res_ord <= target;
            state <= S_OUT;
          end else begin
            cur <= found_o;
            bp <= AW'(head[found_o]);
            ul_p <= AW'(head[found_o]);
            ul_o <= found_o;
            ul_order <= target;
            ret <= S_SPLIT;
            state <= S_UE;
          end
        end
        S_SPLIT: begin
          if (cur > target) begin
            cur <= cur - 1'b1;
            ps_o <= cur - 1'b1;
            ps_p <= bp + (AW'(1) << (cur - 1'b1));
            ret <= S_SPLIT;
            state <= S_PW;
          end else begin
            res_pg <= PG_W'(bp);
            res_ord <= target;
            alloc_ok <= 1'b1;
            state <= S_OUT;
          end
        end
        S_FCHK: begin
          res_pg <= bp_in;
          if (32'(bp_in) >= PAGES) begin
            res_st <= ST_BAD_FREE;
            state <= S_OUT;
          end else begin
            p <= AW'(bp_in);
            state <= S_FE;
          end
        end
        S_FE: begin
          if (rd.free) begin
            res_st <= ST_BAD_FREE;
            res_ord <= rd.order;
            state <= S_OUT;
          end else begin
            o <= (rd.order > TOP) ? TOP : rd.order;
            state <= S_FLOOP;
          end
        end
        S_FLOOP: begin
          if (o >= TOP || bd_oob) begin
            ps_p <= p;
            ps_o <= o;
            res_pg <= PG_W'(p);
            res_ord <= o;
            ret <= S_OUT;
            state <= S_PW;
          end else begin
            bd <= bd_c;
            state <= S_FBD;
          end
        end
        S_FBD: begin
          if (!rd.free || rd.order != o ||
              (rd.prv >= NIL && head[o] != LW'(bd))) begin
            if (rd.free && rd.order == o) begin
              res_st <= ST_BAD_FREE;
            end
            ps_p <= p;
            ps_o <= o;
            res_pg <= PG_W'(p);
            res_ord <= o;
            ret <= S_OUT;
            state <= S_PW;
          end else begin
            ul_p <= bd;
            ul_o <= o;
            ul_order <= o;
            if (bd < p) begin
              p <= bd;
            end
            o <= o + 1'b1;
            ret <= S_FLOOP;
            state <= S_UE;
          end
        end
        S_UE: begin
          ul_q <= rd.prv;
          ul_n <= rd.nxt;
          if (rd.prv < NIL) begin
            state <= S_UQ;
          end else begin
            head[ul_o] <= rd.nxt;
            state <= (rd.nxt < NIL) ? S_UN : ret;
          end
        end
        S_UQ: state <= (ul_n < NIL) ? S_UN : ret;
        S_UN: state <= ret;
        S_PW: begin
          head[ps_o] <= LW'(ps_p);
          ph <= head[ps_o];
          state <= (head[ps_o] < NIL) ? S_PH : ret;
        end
        S_PH: state <= ret;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            status <= res_st;
            page_index <= res_pg;
            block_order <= ORD_W'(res_ord);
            byte_offset <= alloc_ok ? (OFF_W'(bp) << PAGE_SHIFT) : '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("request accepted but sequencer idle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("state RAM written while idle");

  a_offset_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> byte_offset == '0)
    else $error("offset set on failed request");

  a_too_large_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TOO_LARGE |-> page_index == '0 && block_order == '0)
    else $error("too-large result carries page or order");

endmodule

`default_nettype wire

### sim/testbench.sv
// Testbench for buddy_page_allocator_core: directed table, then random alloc/free traffic.
// Each word is checked field by field against an in-bench buddy free-list model.
// Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  localparam int NPG = DEF_PAGES;
  localparam int TOPO = DEF_TOP_ORDER;
  localparam int NIL = 64;
  localparam int N_RANDOM = 1630;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [PG_W-1:0]  pg;
    logic [ORD_W-1:0] ord;
    logic [OFF_W-1:0] off;
  } result_t;

  typedef struct {
    logic              rt;
    logic [SIZE_W-1:0] size;
    logic [PG_W-1:0]   page;
    logic              fixed;
    result_t           res;
  } stim_t;

  logic clk, rst;
  logic in_valid, in_ready, req_type, out_valid, out_ready;
  logic [SIZE_W-1:0] request_size;
  logic [PG_W-1:0] block_page;
  logic [ST_W-1:0] status;
  logic [PG_W-1:0] page_index;
  logic [ORD_W-1:0] block_order;
  logic [OFF_W-1:0] byte_offset;

  buddy_page_allocator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .request_size(request_size), .block_page(block_page),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .page_index(page_index),
    .block_order(block_order), .byte_offset(byte_offset)
  );

  // model state
  bit       pfree[NIL];
  int       pord[NIL];
  int       nxt[NIL];
  int       prv[NIL];
  int       head[TOPO+1];
  int       held[$];

  result_t  pending[$];
  int       errors = 0;
  int       cycles = 0;
  bit       stim_done = 0;
  bit       long_hold = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void push_blk(int o, int p);
    nxt[p] = head[o];
    prv[p] = NIL;
    if (head[o] < NIL) prv[head[o]] = p;
    head[o] = p;
    pfree[p] = 1;
    pord[p] = o;
  endfunction

  function automatic void unlink_blk(int o, int p);
    if (prv[p] < NIL) nxt[prv[p]] = nxt[p];
    else head[o] = nxt[p];
    if (nxt[p] < NIL) prv[nxt[p]] = prv[p];
    nxt[p] = NIL;
    prv[p] = NIL;
    pfree[p] = 0;
  endfunction

  function automatic void reset_heap();
    for (int i = 0; i < NIL; i++) begin
      pfree[i] = 0; pord[i] = 0; nxt[i] = NIL; prv[i] = NIL;
    end
    for (int i = 0; i <= TOPO; i++) head[i] = NIL;
    push_blk(TOPO, 0);
  endfunction

  function automatic int order_for(logic [SIZE_W-1:0] size);
    longint unsigned pages;
    int o;
    pages = (longint'(size) + (64'd1 << DEF_PAGE_SHIFT) - 1) >> DEF_PAGE_SHIFT;
    o = 0;
    while (o < 40 && (64'd1 << o) < pages) o++;
    return o;
  endfunction

  function automatic result_t heap_step(logic rt, logic [SIZE_W-1:0] size,
                                        logic [PG_W-1:0] page);
    result_t r;
    int tgt, cur, b, p, o, bd;
    r = '0;
    if (rt == REQ_ALLOC) begin
      tgt = order_for(size);
      if (tgt > TOPO) begin
        r.st = ST_TOO_LARGE;
      end else begin
        cur = tgt;
        while (cur <= TOPO && head[cur] >= NIL) cur++;
        if (cur > TOPO) begin
          r.st = ST_NO_MEM;
          r.ord = ORD_W'(tgt);
        end else begin
          b = head[cur];
          unlink_blk(cur, b);
          while (cur > tgt) begin
            cur--;
            push_blk(cur, b + (1 << cur));
          end
          pfree[b] = 0;
          pord[b] = tgt;
          r.pg = PG_W'(b);
          r.ord = ORD_W'(tgt);
          r.off = OFF_W'(b << DEF_PAGE_SHIFT);
          held.push_back(b);
        end
      end
    end else begin
      p = int'(page);
      r.pg = PG_W'(p);
      if (pfree[p]) begin
        r.st = ST_BAD_FREE;
        r.ord = ORD_W'(pord[p]);
      end else begin
        o = pord[p];
        if (o > TOPO) o = TOPO;
        while (o < TOPO) begin
          bd = p ^ (1 << o);
          if (bd >= NPG) break;
          if (!pfree[bd] || pord[bd] != o) break;
          if (prv[bd] >= NIL && head[o] != bd) begin
            r.st = ST_BAD_FREE;
            break;
          end
          unlink_blk(o, bd);
          if (bd < p) p = bd;
          o++;
        end
        push_blk(o, p);
        r.pg = PG_W'(p);
        r.ord = ORD_W'(o);
      end
    end
    return r;
  endfunction

  // sender
  task automatic send_word(logic rt, logic [SIZE_W-1:0] size, logic [PG_W-1:0] page,
                           bit burst);
    result_t r;
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rt;
    request_size <= size;
    block_page <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = heap_step(rt, size, page);
    pending.push_back(r);
  endtask

  function automatic logic [SIZE_W-1:0] size_for(int o);
    logic [SIZE_W-1:0] lo, hi;
    hi = SIZE_W'(64'd1 << (o + DEF_PAGE_SHIFT));
    lo = (o == 0) ? 0 : (hi >> 1) + 1;
    return $urandom_range(hi, lo);
  endfunction

  stim_t dir_tab[$];

  task automatic run_directed();
    stim_t s;
    result_t r;
    // after reset, extremes, error codes
    dir_tab = '{
      '{REQ_ALLOC, 32'hFFFF_FFFF, 6'd0, 1, '{ST_TOO_LARGE, 6'd0, 3'd0, 27'd0}},
      '{REQ_ALLOC, 32'h0800_0001, 6'd0, 1, '{ST_TOO_LARGE, 6'd0, 3'd0, 27'd0}},
      '{REQ_FREE, 32'd0, 6'd0, 1, '{ST_BAD_FREE, 6'd0, 3'd6, 27'd0}},
      '{REQ_ALLOC, 32'h0800_0000, 6'd0, 1, '{ST_OK, 6'd0, 3'd6, 27'd0}},
      '{REQ_ALLOC, 32'd0, 6'd0, 1, '{ST_NO_MEM, 6'd0, 3'd0, 27'd0}},
      '{REQ_ALLOC, 32'h0400_0000, 6'd0, 1, '{ST_NO_MEM, 6'd0, 3'd5, 27'd0}},
      '{REQ_FREE, 32'hFFFF_FFFF, 6'd0, 1, '{ST_OK, 6'd0, 3'd6, 27'd0}},
      '{REQ_ALLOC, 32'd1, 6'd0, 0, '0},
      '{REQ_ALLOC, 32'h0020_0000, 6'd0, 0, '0},
      '{REQ_ALLOC, 32'h0020_0001, 6'd0, 0, '0},
      '{REQ_ALLOC, 32'h0040_0001, 6'd0, 0, '0},
      '{REQ_FREE, 32'd0, 6'd63, 0, '0},
      '{REQ_FREE, 32'd0, 6'd63, 0, '0},
      '{REQ_FREE, 32'd0, 6'd1, 0, '0},
      '{REQ_FREE, 32'd0, 6'd0, 0, '0},
      '{REQ_FREE, 32'd0, 6'd2, 0, '0},
      '{REQ_FREE, 32'd0, 6'd4, 0, '0},
      '{REQ_FREE, 32'd0, 6'd0, 0, '0},
      '{REQ_FREE, 32'd0, 6'd37, 0, '0},
      '{REQ_ALLOC, 32'h0200_0000, 6'd0, 0, '0},
      '{REQ_ALLOC, 32'h0400_0000, 6'd0, 0, '0},
      '{REQ_ALLOC, 32'h0800_0000, 6'd0, 0, '0}
    };
    foreach (dir_tab[i]) begin
      s = dir_tab[i];
      send_word(s.rt, s.size, s.page, 0);
      if (s.fixed) begin
        r = pending.pop_back();
        if (r != s.res) begin
          $display("%0t directed row %0d: expected %h actual %h", $time, i, s.res, r);
          errors++;
        end
        pending.push_back(s.res);
      end
    end
  endtask

  task automatic run_random();
    int k, idx;
    logic [PG_W-1:0] pg;
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 99);
      if (n == 200) long_hold = 1;
      if (k < 45) begin
        send_word(REQ_ALLOC, size_for($urandom_range(0, 3) == 0 ?
                  $urandom_range(0, 6) : $urandom_range(0, 2)), 6'd0, n > 200 && n < 216);
      end else if (k < 50) begin
        send_word(REQ_ALLOC, $urandom, 6'd0, 0);
      end else if (k < 90 && held.size() > 0) begin
        idx = $urandom_range(0, held.size() - 1);
        pg = PG_W'(held[idx]);
        held.delete(idx);
        send_word(REQ_FREE, $urandom, pg, 0);
      end else begin
        // noise: random page, may be a double free or a non-head page
        pg = PG_W'($urandom);
        foreach (held[j]) if (held[j] == pg) begin held.delete(j); break; end
        send_word(REQ_FREE, $urandom, pg, 0);
      end
    end
  endtask

  // receiver
  initial begin
    int gap;
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected word st=%0d pg=%0d ord=%0d off=%0h", $time,
                 status, page_index, block_order, byte_offset);
        errors++;
      end else begin
        e = pending.pop_front();
        if (status !== e.st) begin
          $display("%0t status: expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (page_index !== e.pg) begin
          $display("%0t page_index: expected %0d actual %0d", $time, e.pg, page_index);
          errors++;
        end
        if (block_order !== e.ord) begin
          $display("%0t block_order: expected %0d actual %0d", $time, e.ord, block_order);
          errors++;
        end
        if (byte_offset !== e.off) begin
          $display("%0t byte_offset: expected %0h actual %0h", $time, e.off, byte_offset);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    req_type = REQ_ALLOC;
    request_size = '0;
    block_page = '0;
    reset_heap();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 0;
    stim_done = 1;
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_store.sv
rtl/core/buddy_page_allocator_core.sv
sim/testbench.sv
